[design/hsai_pkg.sv]
// Shared types, constants and the sector angle table for the Hall sector angle interpolator.
// Used by every module of the block; depends on nothing.
package hsai_pkg;

   localparam int PERIOD_BITS     = 16;
   localparam int ANGLE_FRAC_BITS = 7;

   localparam int PP_W    = 7;
   localparam int TO_W    = 16;
   localparam int HZ_W    = 28;
   localparam int CSR_W   = 28;
   localparam int DEN_W   = PERIOD_BITS + PP_W;
   localparam int NUM_RAW = 16 + 6 + ANGLE_FRAC_BITS;
   localparam int NUM_W   = (NUM_RAW > 32) ? (2 * ((NUM_RAW + 1) / 2)) : 32;
   localparam int STEPS   = NUM_W / 2;
   localparam int CNT_W   = $clog2(STEPS);
   localparam int ANG_W   = 9 + ANGLE_FRAC_BITS + 1;

   localparam logic [ANG_W-1:0] SECTOR_SPAN = ANG_W'(60) << ANGLE_FRAC_BITS;
   localparam logic [ANG_W-1:0] FULL_TURN   = ANG_W'(360) << ANGLE_FRAC_BITS;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_INIT    = 2'd0;
   localparam opcode_type OP_CAPTURE = 2'd1;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_STALL_TIMEOUT = 2'd0;
   localparam csr_index_type CSR_PAIR_COUNT    = 2'd1;
   localparam csr_index_type CSR_TIMER_HZ      = 2'd2;

   typedef struct packed {
      logic [TO_W-1:0] stall_timeout_ms;
      logic [PP_W-1:0] pair_count;
      logic [HZ_W-1:0] timer_hz;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_status_type;

   function automatic logic [8:0] base_deg(input logic [2:0] sector);
      logic [8:0] deg;
      case (sector)
         3'd1: deg = 9'd330;
         3'd2: deg = 9'd90;
         3'd3: deg = 9'd30;
         3'd4: deg = 9'd210;
         3'd5: deg = 9'd270;
         3'd6: deg = 9'd150;
         default: deg = 9'd0;
      endcase
      return deg;
   endfunction

endpackage

[design/hsai_req_if.sv]
// Request channel of the Hall sector angle interpolator: valid, ready and the request fields.
// Depends on nothing.
interface hsai_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  hall_bits;
   logic [15:0] captured_period;
   logic [15:0] counter_now;
   logic [31:0] time_ms;

   modport source (output valid, opcode, hall_bits, captured_period, counter_now, time_ms,
                   input ready);
   modport sink (input valid, opcode, hall_bits, captured_period, counter_now, time_ms,
                 output ready);
endinterface

[design/hsai_rsp_if.sv]
// Response channel of the Hall sector angle interpolator: valid, ready and the result fields.
// Depends on nothing.
interface hsai_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] angle;
   logic [2:0]  sector_out;
   logic [15:0] speed_rpm;
   logic        stalled;

   modport source (output valid, angle, sector_out, speed_rpm, stalled, input ready);
   modport sink (input valid, angle, sector_out, speed_rpm, stalled, output ready);
endinterface

[design/hsai_csr.sv]
// Configuration registers of the Hall sector angle interpolator.
// Depends on hsai_pkg.
module hsai_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  hsai_pkg::csr_index_type csr_index,
   input  logic [hsai_pkg::CSR_W-1:0] csr_wdata,
   output hsai_pkg::cfg_type      cfg
);
   import hsai_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STALL_TIMEOUT: cfg_in.stall_timeout_ms = csr_wdata[TO_W-1:0];
            CSR_PAIR_COUNT:    cfg_in.pair_count = csr_wdata[PP_W-1:0];
            CSR_TIMER_HZ:      cfg_in.timer_hz = csr_wdata[HZ_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_timeout_ms <= TO_W'(100);
         cfg_ff.pair_count <= PP_W'(15);
         cfg_ff.timer_hz <= HZ_W'(1000000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/hsai_divider.sv]
// Shared restoring divider that produces two quotient bits per cycle.
// Depends on hsai_pkg.
module hsai_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  hsai_pkg::div_cmd_type      cmd,
   output hsai_pkg::div_status_type   status
);
   import hsai_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   r1, r2;
   logic [DEN_W-1:0] r1s;
   logic             ge1, ge2;

   always_comb begin
      r1  = {rem_ff, num_ff[NUM_W-1]};
      ge1 = r1 >= {1'b0, den_ff};
      r1s = ge1 ? DEN_W'(r1 - {1'b0, den_ff}) : r1[DEN_W-1:0];
      r2  = {r1s, num_ff[NUM_W-2]};
      ge2 = r2 >= {1'b0, den_ff};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;

      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         num_in   = cmd.dividend;
         den_in   = cmd.divisor;
      end else if (busy_ff) begin
         rem_in   = ge2 ? DEN_W'(r2 - {1'b0, den_ff}) : r2[DEN_W-1:0];
         num_in   = {num_ff[NUM_W-3:0], ge1, ge2};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = num_ff;

endmodule

[design/hall_sector_angle_interpolator.sv]
// Top level of the Hall sector angle interpolator: sensor state, sequencer and result register.
// Depends on hsai_pkg, hsai_req_if, hsai_rsp_if, hsai_csr and hsai_divider.
//
// The block takes one request at a time and answers each with one response. A request that
// needs both divisions runs them in turn on one shared divider, which yields two quotient bits
// per cycle: first the in-sector angle, then the speed. When the motor is stalled or the
// period is zero both divisions are skipped; when the pole pair count is zero only the speed
// division is skipped. A new request is taken as soon as the previous one has been handed to
// the response register, even while that response still waits. Configuration writes take
// effect at once and must be made only while the block is idle.
module hall_sector_angle_interpolator (
   input  logic                          clock,
   input  logic                          reset,
   hsai_req_if.sink                      req,
   hsai_rsp_if.source                    rsp,
   input  logic                          csr_wr_en,
   input  hsai_pkg::csr_index_type       csr_index,
   input  logic [hsai_pkg::CSR_W-1:0]    csr_wdata
);
   import hsai_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_A,
      ST_WAIT_A,
      ST_START_R,
      ST_WAIT_R,
      ST_FIN
   } state_type;

   cfg_type        cfg;
   div_cmd_type    div_cmd;
   div_status_type div_status;

   state_type              state_ff, state_in;
   logic [2:0]             sector_ff, sector_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [31:0]            last_ff, last_in;
   logic                   stalled_ff, stalled_in;
   logic [15:0]            counter_ff, counter_in;
   logic [DEN_W-1:0]       prod_ff, prod_in;
   logic [ANG_W-1:0]       angle_ff, angle_in;
   logic [15:0]            rpm_ff, rpm_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_angle_ff, rsp_angle_in;
   logic [2:0]             rsp_sector_ff, rsp_sector_in;
   logic [15:0]            rsp_rpm_ff, rsp_rpm_in;
   logic                   rsp_stalled_ff, rsp_stalled_in;

   logic                   accept;
   logic [31:0]            elapsed;
   logic [31:0]            cap_ext;
   logic [ANG_W-1:0]       base_ang;
   logic [ANG_W-1:0]       inner;
   logic [ANG_W-1:0]       ang_sum;
   logic [31:0]            ang_out;

   hsai_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hsai_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .status (div_status)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign cap_ext   = {16'd0, req.captured_period};
   assign base_ang  = ANG_W'(base_deg(sector_ff)) << ANGLE_FRAC_BITS;
   assign inner     = (div_status.quotient > NUM_W'(SECTOR_SPAN)) ? SECTOR_SPAN
                      : div_status.quotient[ANG_W-1:0];
   assign ang_sum   = base_ang + inner;
   assign ang_out   = 32'(angle_ff);

   always_comb begin
      state_in   = state_ff;
      sector_in  = sector_ff;
      period_in  = period_ff;
      last_in    = last_ff;
      stalled_in = stalled_ff;
      counter_in = counter_ff;
      prod_in    = prod_ff;
      angle_in   = angle_ff;
      rpm_in     = rpm_ff;
      elapsed    = '0;

      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_angle_in   = rsp_angle_ff;
      rsp_sector_in  = rsp_sector_ff;
      rsp_rpm_in     = rsp_rpm_ff;
      rsp_stalled_in = rsp_stalled_ff;

      div_cmd.start    = 1'b0;
      div_cmd.dividend = (NUM_W'(counter_ff) * NUM_W'(60)) << ANGLE_FRAC_BITS;
      div_cmd.divisor  = DEN_W'(period_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               counter_in = req.counter_now;
               if (req.opcode == OP_INIT) begin
                  sector_in = req.hall_bits;
               end else if (req.opcode == OP_CAPTURE) begin
                  period_in = cap_ext[PERIOD_BITS-1:0];
                  last_in   = req.time_ms;
                  if (req.hall_bits != 3'd0 && req.hall_bits != 3'd7) begin
                     sector_in = req.hall_bits;
                  end
               end
               elapsed    = req.time_ms - last_in;
               stalled_in = elapsed > 32'(cfg.stall_timeout_ms);
               if (stalled_in) begin
                  period_in = '0;
               end
               state_in = ST_START_A;
            end
         end
         ST_START_A: begin
            prod_in = DEN_W'(period_ff) * DEN_W'(cfg.pair_count);
            if (period_ff != '0) begin
               div_cmd.start = 1'b1;
               state_in = ST_WAIT_A;
            end else begin
               angle_in = base_ang;
               state_in = ST_START_R;
            end
         end
         ST_WAIT_A: begin
            if (div_status.done) begin
               angle_in = (ang_sum >= FULL_TURN) ? ang_sum - FULL_TURN : ang_sum;
               state_in = ST_START_R;
            end
         end
         ST_START_R: begin
            div_cmd.dividend = NUM_W'(32'(cfg.timer_hz) * 32'd10);
            div_cmd.divisor  = prod_ff;
            if (period_ff != '0 && cfg.pair_count != '0) begin
               div_cmd.start = 1'b1;
               state_in = ST_WAIT_R;
            end else begin
               rpm_in   = '0;
               state_in = ST_FIN;
            end
         end
         ST_WAIT_R: begin
            if (div_status.done) begin
               rpm_in = (div_status.quotient > NUM_W'(16'hFFFF)) ? 16'hFFFF
                        : div_status.quotient[15:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_angle_in   = ang_out[15:0];
               rsp_sector_in  = sector_ff;
               rsp_rpm_in     = rpm_ff;
               rsp_stalled_in = stalled_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sector_ff    <= '0;
         period_ff    <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sector_ff    <= sector_in;
         period_ff    <= period_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stalled_ff     <= stalled_in;
      counter_ff     <= counter_in;
      prod_ff        <= prod_in;
      angle_ff       <= angle_in;
      rpm_ff         <= rpm_in;
      rsp_angle_ff   <= rsp_angle_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_rpm_ff     <= rsp_rpm_in;
      rsp_stalled_ff <= rsp_stalled_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.angle      = rsp_angle_ff;
   assign rsp.sector_out = rsp_sector_ff;
   assign rsp.speed_rpm  = rsp_rpm_ff;
   assign rsp.stalled    = rsp_stalled_ff;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for hall_sector_angle_interpolator: a directed table of requests,
// then random motor-like request sequences under several register settings and random stalls.
// Depends on hsai_pkg, hsai_req_if, hsai_rsp_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
   import hsai_pkg::*;

   localparam opcode_type OP_QUERY = 2'd2;
   localparam opcode_type OP_SPARE = 2'd3;
   localparam longint unsigned ONE_DEG = 64'd1 << ANGLE_FRAC_BITS;
   localparam longint unsigned SPAN_UNITS = 60 * ONE_DEG;
   localparam longint unsigned TURN_UNITS = 360 * ONE_DEG;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_REQUESTS = 225;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [8:0] SECTOR_BASE_DEG [8] = '{9'd0, 9'd330, 9'd90, 9'd30,
                                                  9'd210, 9'd270, 9'd150, 9'd0};
   localparam logic [2:0] HALL_ORDER [6] = '{3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd1};

   typedef struct packed {
      opcode_type  opcode;
      logic [2:0]  hall_bits;
      logic [15:0] captured_period;
      logic [15:0] counter_now;
      logic [31:0] time_ms;
   } hall_req_type;

   typedef struct packed {
      logic [15:0] angle;
      logic [2:0]  sector_out;
      logic [15:0] speed_rpm;
      logic        stalled;
   } rotor_est_type;

   typedef struct packed {
      logic        typed;
      opcode_type  opcode;
      logic [2:0]  hall_bits;
      logic [15:0] captured_period;
      logic [15:0] counter_now;
      logic [31:0] time_ms;
      logic [15:0] x_angle;
      logic [2:0]  x_sector;
      logic [15:0] x_rpm;
      logic        x_stalled;
   } dir_row_type;

   dir_row_type dir_table [$] = '{
      '{1'b1, OP_QUERY,   3'd0, 16'd0,     16'd0,     32'd0,          16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b1, OP_INIT,    3'd7, 16'd0,     16'd0,     32'd0,          16'd0,     3'd7, 16'd0,     1'b0},
      '{1'b1, OP_INIT,    3'd0, 16'd0,     16'd0,     32'd0,          16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b1, OP_INIT,    3'd1, 16'd0,     16'd0,     32'd5,          16'd42240, 3'd1, 16'd0,     1'b0},
      '{1'b1, OP_CAPTURE, 3'd2, 16'd1000,  16'd0,     32'd10,         16'd11520, 3'd2, 16'd666,   1'b0},
      '{1'b0, OP_QUERY,   3'd5, 16'd0,     16'd500,   32'd20,         16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b0, OP_QUERY,   3'd0, 16'd0,     16'd65535, 32'd30,         16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b0, OP_CAPTURE, 3'd1, 16'd1000,  16'd999,   32'd40,         16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b0, OP_CAPTURE, 3'd0, 16'd65535, 16'd1,     32'd50,         16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b1, OP_CAPTURE, 3'd7, 16'd1,     16'd65535, 32'd60,         16'd3840,  3'd1, 16'd65535, 1'b0},
      '{1'b1, OP_QUERY,   3'd0, 16'd0,     16'd0,     32'd161,        16'd42240, 3'd1, 16'd0,     1'b1},
      '{1'b1, OP_QUERY,   3'd0, 16'd0,     16'd100,   32'd161,        16'd42240, 3'd1, 16'd0,     1'b1},
      '{1'b0, OP_SPARE,   3'd6, 16'd77,    16'd0,     32'd161,        16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b1, OP_CAPTURE, 3'd3, 16'd0,     16'd12345, 32'd200,        16'd3840,  3'd3, 16'd0,     1'b0},
      '{1'b0, OP_CAPTURE, 3'd2, 16'd200,   16'd100,   32'd1000,       16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b0, OP_QUERY,   3'd0, 16'd0,     16'd50,    32'd1100,       16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b1, OP_QUERY,   3'd0, 16'd0,     16'd50,    32'd1101,       16'd11520, 3'd2, 16'd0,     1'b1},
      '{1'b0, OP_CAPTURE, 3'd4, 16'd65535, 16'd0,     32'hFFFF_FFF0,  16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b0, OP_QUERY,   3'd0, 16'd0,     16'd32768, 32'h0000_0010,  16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b0, OP_CAPTURE, 3'd5, 16'd12345, 16'd65535, 32'hFFFF_FFFF,  16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b0, OP_CAPTURE, 3'd6, 16'd1,     16'd0,     32'hFFFF_FFFF,  16'd0,     3'd0, 16'd0,     1'b0},
      '{1'b1, OP_QUERY,   3'd0, 16'd0,     16'd65535, 32'h7FFF_FFFF,  16'd19200, 3'd6, 16'd0,     1'b1},
      '{1'b1, OP_INIT,    3'd3, 16'd0,     16'd0,     32'h7FFF_FFFF,  16'd3840,  3'd3, 16'd0,     1'b1}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_wdata;

   hsai_req_if req_ch ();
   hsai_rsp_if rsp_ch ();

   hall_sector_angle_interpolator dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [15:0] cfg_timeout;
   logic [6:0]  cfg_poles;
   logic [27:0] cfg_hz;
   logic [2:0]  trk_sector;
   logic [15:0] trk_period;
   logic [31:0] trk_edge_ms;

   rotor_est_type est_q [$];
   int fail_count;
   int sent_count;
   int checked_count;
   int stalled_seen;
   int saturated_seen;
   int cycle_count;
   int gap_odds;
   int stall_odds;

   int          mot_step;
   logic [31:0] mot_ms;
   logic [31:0] mot_edge_ms;
   int unsigned mot_period;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("hall_sector_angle_interpolator: mismatch");
      $finish;
   end

   function automatic rotor_est_type predict_rotor(input hall_req_type r);
      rotor_est_type e;
      logic [31:0] elapsed;
      logic stall;
      longint unsigned ang;
      longint unsigned inner;
      longint unsigned rpm;
      case (r.opcode)
         OP_INIT: trk_sector = r.hall_bits;
         OP_CAPTURE: begin
            trk_period = r.captured_period;
            trk_edge_ms = r.time_ms;
            if (r.hall_bits != 3'd0 && r.hall_bits != 3'd7) trk_sector = r.hall_bits;
         end
         default: ;
      endcase
      elapsed = r.time_ms - trk_edge_ms;
      stall = elapsed > {16'd0, cfg_timeout};
      if (stall) trk_period = '0;
      ang = longint'(SECTOR_BASE_DEG[trk_sector]) * ONE_DEG;
      rpm = 0;
      if (!stall && trk_period != 0) begin
         inner = (longint'(r.counter_now) * SPAN_UNITS) / longint'(trk_period);
         if (inner > SPAN_UNITS) inner = SPAN_UNITS;
         ang = ang + inner;
         if (ang >= TURN_UNITS) ang = ang - TURN_UNITS;
         if (cfg_poles != 0) begin
            rpm = (longint'(cfg_hz) * 10) / (longint'(trk_period) * longint'(cfg_poles));
            if (rpm > 65535) rpm = 65535;
         end
      end
      e.angle = ang[15:0];
      e.sector_out = trk_sector;
      e.speed_rpm = rpm[15:0];
      e.stalled = stall;
      return e;
   endfunction

   function automatic logic [31:0] pick_elapsed();
      if ($urandom_range(0, 9) == 0) return {16'd0, cfg_timeout} + $urandom_range(1, 3000);
      return $urandom_range(0, cfg_timeout);
   endfunction

   // Mostly a rotating motor: captures walk the Hall order, queries land in the sector or up to an eighth past it.
   function automatic hall_req_type next_motor_request();
      hall_req_type r;
      int unsigned pick;
      int unsigned span;
      pick = $urandom_range(0, 99);
      r.opcode = OP_QUERY;
      r.hall_bits = 3'($urandom);
      r.captured_period = 16'($urandom);
      r.counter_now = 16'($urandom);
      r.time_ms = $urandom;
      if (pick < 8) begin
         r.opcode = opcode_type'($urandom_range(0, 3));
      end else if (pick < 13) begin
         r.opcode = OP_INIT;
         r.time_ms = mot_ms;
         if ($urandom_range(0, 1) == 1) r.hall_bits = HALL_ORDER[mot_step];
      end else if (pick < 45) begin
         r.opcode = OP_CAPTURE;
         if ($urandom_range(0, 9) == 0) mot_step = (mot_step + 5) % 6;
         else mot_step = (mot_step + 1) % 6;
         if ($urandom_range(0, 19) == 0) r.hall_bits = ($urandom_range(0, 1) == 1) ? 3'd7 : 3'd0;
         else r.hall_bits = HALL_ORDER[mot_step];
         pick = $urandom_range(0, 99);
         if (pick < 3) mot_period = 0;
         else if (pick < 60) mot_period = $urandom_range(1, 4000);
         else mot_period = $urandom_range(1, 65535);
         r.captured_period = 16'(mot_period);
         mot_ms = mot_ms + $urandom_range(0, cfg_timeout / 4);
         mot_edge_ms = mot_ms;
         r.time_ms = mot_ms;
      end else begin
         r.opcode = ($urandom_range(0, 15) == 0) ? OP_SPARE : OP_QUERY;
         span = mot_period + mot_period / 8;
         if (span > 65535) span = 65535;
         r.counter_now = 16'($urandom_range(0, span));
         mot_ms = mot_edge_ms + pick_elapsed();
         r.time_ms = mot_ms;
      end
      return r;
   endfunction

   task automatic send_request(input hall_req_type r, input logic use_typed,
                               input rotor_est_type typed);
      rotor_est_type e;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.opcode = r.opcode;
      req_ch.hall_bits = r.hall_bits;
      req_ch.captured_period = r.captured_period;
      req_ch.counter_now = r.counter_now;
      req_ch.time_ms = r.time_ms;
      do @(posedge clock); while (!req_ch.ready);
      e = predict_rotor(r);
      est_q.push_back(use_typed ? typed : e);
      sent_count++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_STALL_TIMEOUT: cfg_timeout = val[15:0];
         CSR_PAIR_COUNT:    cfg_poles = val[6:0];
         CSR_TIMER_HZ:      cfg_hz = val[27:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (est_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_phase(input int ph);
      logic [CSR_W-1:0] to_val;
      logic [CSR_W-1:0] pp_val;
      logic [CSR_W-1:0] hz_val;
      case (ph)
         0: begin to_val = 100; pp_val = 15; hz_val = 1000000; gap_odds = 4; stall_odds = 4; end
         1: begin to_val = 0; pp_val = 1; hz_val = 1; gap_odds = 3; stall_odds = 6; end
         2: begin
            to_val = 65535; pp_val = 64; hz_val = 170000000; gap_odds = 6; stall_odds = 3;
         end
         3: begin
            to_val = $urandom_range(0, 65535); pp_val = 127; hz_val = 28'hFFF_FFFF;
            gap_odds = 2; stall_odds = 2;
         end
         4: begin
            to_val = 50; pp_val = 0; hz_val = $urandom_range(1, 170000000);
            gap_odds = 5; stall_odds = 8;
         end
         default: begin
            to_val = $urandom_range(0, 65535); pp_val = $urandom_range(1, 64);
            hz_val = $urandom_range(1, 170000000); gap_odds = 0; stall_odds = 0;
         end
      endcase
      write_csr(CSR_STALL_TIMEOUT, to_val);
      write_csr(CSR_PAIR_COUNT, pp_val);
      write_csr(CSR_TIMER_HZ, hz_val);
      mot_step = $urandom_range(0, 5);
      mot_ms = $urandom;
      mot_edge_ms = mot_ms;
      mot_period = 1000;
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rotor_est_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (est_q.size() == 0) begin
            $error("response with no request outstanding: angle %0d sector %0d",
                   rsp_ch.angle, rsp_ch.sector_out);
            fail_count++;
         end else begin
            want = est_q.pop_front();
            check_field("angle", want.angle, rsp_ch.angle);
            check_field("sector_out", want.sector_out, rsp_ch.sector_out);
            check_field("speed_rpm", want.speed_rpm, rsp_ch.speed_rpm);
            check_field("stalled", want.stalled, rsp_ch.stalled);
            checked_count++;
            if (rsp_ch.stalled) stalled_seen++;
            if (rsp_ch.speed_rpm == 16'hFFFF) saturated_seen++;
         end
      end
   end

   initial begin
      hall_req_type r;
      rotor_est_type typed;
      cycle_count = 0;
      fail_count = 0;
      sent_count = 0;
      checked_count = 0;
      stalled_seen = 0;
      saturated_seen = 0;
      gap_odds = 4;
      stall_odds = 4;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_STALL_TIMEOUT;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_INIT;
      req_ch.hall_bits = '0;
      req_ch.captured_period = '0;
      req_ch.counter_now = '0;
      req_ch.time_ms = '0;
      cfg_timeout = 16'd100;
      cfg_poles = 7'd15;
      cfg_hz = 28'd1000000;
      trk_sector = '0;
      trk_period = '0;
      trk_edge_ms = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i]) begin
         r.opcode = dir_table[i].opcode;
         r.hall_bits = dir_table[i].hall_bits;
         r.captured_period = dir_table[i].captured_period;
         r.counter_now = dir_table[i].counter_now;
         r.time_ms = dir_table[i].time_ms;
         typed.angle = dir_table[i].x_angle;
         typed.sector_out = dir_table[i].x_sector;
         typed.speed_rpm = dir_table[i].x_rpm;
         typed.stalled = dir_table[i].x_stalled;
         send_request(r, dir_table[i].typed, typed);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_drained();
         set_phase(ph);
         for (int k = 0; k < PHASE_REQUESTS; k++) begin
            if (k == PHASE_REQUESTS / 2) wait_drained();
            send_request(next_motor_request(), 1'b0, typed);
         end
      end

      while (est_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d requests (%0d from the directed table) over %0d register settings;",
               sent_count, dir_table.size(), RANDOM_PHASES + 1);
      $display("checked %0d responses, %0d of them stalled and %0d with saturated speed.",
               checked_count, stalled_seen, saturated_seen);
      if (fail_count == 0) begin
         $display("hall_sector_angle_interpolator: match");
      end else begin
         $display("hall_sector_angle_interpolator: mismatch");
      end
      $finish;
   end

endmodule
